@@ hw/rtl/assert_macros.svh @@
// Shared assertion macros. Each one samples on clk_i and is switched off
// while rst_ni is low, so the module that uses them must have both names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rsm_pkg.sv @@
package rsm_pkg;

  // Widths fixed by the interface.
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned EXP_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

  // Reset value of the public exponent.
  localparam logic [EXP_W-1:0] PUBLIC_EXP_RESET = 32'd3;

  // Operation codes carried by the func field.
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new item and start reducing its base
    logic mul_acc;    // product register takes acc * base
    logic mul_sq;     // product register takes base * base
    logic red_step;   // one bit of the serial reduction
    logic wr_base;    // remainder goes to the base register
    logic wr_acc;     // remainder goes to the accumulator
    logic shift_exp;  // drop the exponent bit just used
    logic finish;     // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;   // configured modulus is zero
    logic red_done;   // all product bits have been folded in
    logic exp_zero;   // no exponent bits left
    logic exp_lsb;    // current exponent bit
    logic exp_last;   // the current exponent bit is the top one
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

endpackage

@@ hw/rtl/rsm_cfg_regs.sv @@
module rsm_cfg_regs #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rsm_pkg::VALUE_W-1:0]          cfg_data_i,
  output logic [MOD_WIDTH-1:0]                 modulus_o,
  output logic [rsm_pkg::EXP_W-1:0]            public_exp_o,
  output logic [rsm_pkg::EXP_W-1:0]            private_exp_o
);

  logic                          wr_en;
  logic [MOD_WIDTH-1:0]          modulus_q;
  logic [rsm_pkg::EXP_W-1:0]     public_exp_q;
  logic [rsm_pkg::EXP_W-1:0]     private_exp_q;

  // Writes must arrive only while the block is idle (not enforced); all are taken.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Register file; only the low bits of the modulus are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= '0;
      public_exp_q  <= rsm_pkg::PUBLIC_EXP_RESET;
      private_exp_q <= '0;
    end else if (wr_en) begin
      case (cfg_index_i)
        rsm_pkg::CFG_MODULUS:     modulus_q     <= cfg_data_i[MOD_WIDTH-1:0];
        rsm_pkg::CFG_PUBLIC_EXP:  public_exp_q  <= cfg_data_i;
        rsm_pkg::CFG_PRIVATE_EXP: private_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign modulus_o     = modulus_q;
  assign public_exp_o  = public_exp_q;
  assign private_exp_o = private_exp_q;

endmodule

@@ hw/rtl/rsm_datapath.sv @@
module rsm_datapath #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsm_pkg::dp_cmd_t              cmd_i,
  output rsm_pkg::dp_status_t           status_o,
  input  logic [MOD_WIDTH-1:0]          modulus_i,
  input  logic [rsm_pkg::EXP_W-1:0]     public_exp_i,
  input  logic [rsm_pkg::EXP_W-1:0]     private_exp_i,
  input  logic                          func_i,
  input  logic [rsm_pkg::VALUE_W-1:0]   message_value_i,
  input  logic                          last_item_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [rsm_pkg::VALUE_W-1:0]   result_value_o,
  output logic                          error_flag_o,
  output logic                          last_out_o
);

  // The product register must also hold a full-width message for the base reduction.
  localparam int unsigned MulW  = 2 * MOD_WIDTH;
  localparam int unsigned ProdW = (MulW > rsm_pkg::VALUE_W) ? MulW : rsm_pkg::VALUE_W;
  localparam int unsigned CntW  = $clog2(ProdW + 1);

  logic [MOD_WIDTH-1:0]          acc_q;
  logic [MOD_WIDTH-1:0]          base_q;
  logic [MOD_WIDTH-1:0]          rem_q;
  logic [ProdW-1:0]              prod_q;
  logic [CntW-1:0]               cnt_q;
  logic [rsm_pkg::EXP_W-1:0]     exp_q;
  logic                          func_q;
  logic                          last_q;
  logic                          err_q;

  logic                          out_valid_q;
  logic [rsm_pkg::VALUE_W-1:0]   out_value_q;
  logic                          out_err_q;
  logic                          out_last_q;

  logic [ProdW-1:0]              load_base;
  logic [MOD_WIDTH-1:0]          mul_a;
  logic [MulW-1:0]               mul_p;
  logic [MOD_WIDTH:0]            trial;
  logic [MOD_WIDTH:0]            diff;
  logic [MOD_WIDTH-1:0]          rem_d;
  logic [rsm_pkg::VALUE_W-1:0]   result_d;

  // Encryption only looks at the low byte of the message.
  assign load_base = (func_i == rsm_pkg::FUNC_DECRYPT) ? ProdW'(message_value_i)
                                                       : ProdW'(message_value_i[rsm_pkg::BYTE_W-1:0]);

  // Single shared multiplier; both operands are already reduced.
  assign mul_a = cmd_i.mul_acc ? acc_q : base_q;
  assign mul_p = MulW'(mul_a) * MulW'(base_q);

  // Restoring reduction: shift in one product bit, subtract the modulus if it fits.
  assign trial = {rem_q, prod_q[ProdW-1]};
  assign diff  = trial - {1'b0, modulus_i};
  assign rem_d = (trial >= {1'b0, modulus_i}) ? diff[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];

  // Product register and reduction counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.mul_acc || cmd_i.mul_sq) begin
      cnt_q <= CntW'(ProdW);
    end else if (cmd_i.red_step) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_q <= load_base;
      rem_q  <= '0;
    end else if (cmd_i.mul_acc || cmd_i.mul_sq) begin
      prod_q <= ProdW'(mul_p);
      rem_q  <= '0;
    end else if (cmd_i.red_step) begin
      prod_q <= prod_q << 1;
      rem_q  <= rem_d;
    end
  end

  // Item registers: accumulator, base, exponent and side-band bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q  <= MOD_WIDTH'(1);
      exp_q  <= (func_i == rsm_pkg::FUNC_DECRYPT) ? private_exp_i : public_exp_i;
      func_q <= func_i;
      last_q <= last_item_i;
      err_q  <= (modulus_i == '0);
    end else begin
      if (cmd_i.wr_acc) begin
        acc_q <= rem_q;
      end
      if (cmd_i.shift_exp) begin
        exp_q <= exp_q >> 1;
      end
    end
    if (cmd_i.wr_base) begin
      base_q <= rem_q;
    end
  end

  // Final formatting: zero on error, low byte only when decrypting.
  always_comb begin
    if (err_q) begin
      result_d = '0;
    end else if (func_q == rsm_pkg::FUNC_DECRYPT) begin
      result_d = rsm_pkg::VALUE_W'(acc_q[rsm_pkg::BYTE_W-1:0]);
    end else begin
      result_d = rsm_pkg::VALUE_W'(acc_q);
    end
  end

  // Output register; it holds a beat until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_value_q <= result_d;
      out_err_q   <= err_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign error_flag_o   = out_err_q;
  assign last_out_o     = out_last_q;

  // Status back to the controller.
  always_comb begin
    status_o          = '0;
    status_o.mod_zero = (modulus_i == '0);
    status_o.red_done = (cnt_q == '0);
    status_o.exp_zero = (exp_q == '0);
    status_o.exp_lsb  = exp_q[0];
    status_o.exp_last = (exp_q[rsm_pkg::EXP_W-1:1] == '0);
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule

@@ hw/rtl/rsm_ctrl.sv @@
module rsm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rsm_pkg::dp_status_t  status_i,
  output rsm_pkg::dp_cmd_t     cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RED_B = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_MUL_A = 3'd3;
  localparam logic [2:0] ST_RED_A = 3'd4;
  localparam logic [2:0] ST_MUL_S = 3'd5;
  localparam logic [2:0] ST_RED_S = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Input is taken only between items.
  assign in_stall_o = (state_q != ST_IDLE);

  // Square-and-multiply sequencing, exponent bits from the bottom up.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.mod_zero ? ST_FIN : ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (status_i.red_done) begin
          cmd_o.wr_base = 1'b1;
          state_d       = ST_CHK;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      ST_CHK: begin
        if (status_i.exp_zero) begin
          state_d = ST_FIN;
        end else if (status_i.exp_lsb) begin
          state_d = ST_MUL_A;
        end else begin
          state_d = ST_MUL_S;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_acc = 1'b1;
        state_d       = ST_RED_A;
      end
      ST_RED_A: begin
        if (status_i.red_done) begin
          cmd_o.wr_acc = 1'b1;
          // The last square would never be used.
          state_d      = status_i.exp_last ? ST_FIN : ST_MUL_S;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      ST_MUL_S: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = ST_RED_S;
      end
      ST_RED_S: begin
        if (status_i.red_done) begin
          cmd_o.wr_base   = 1'b1;
          cmd_o.shift_exp = 1'b1;
          state_d         = ST_CHK;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/rsa_symbol_modexp.sv @@
// Per item the base is first reduced modulo the modulus; then, for each exponent bit from the
// bottom up, a decision state, a multiply when the bit is set and a square except after the top
// bit, each followed by a serial reduction of PW = max(2*MOD_WIDTH, 32) product bits; then ST_FIN.
// A zero exponent goes to ST_FIN after the base reduction, a zero modulus straight away.
// One item is in work at a time; a result waiting in the output register does not block the
// next input beat. Reset (rst_ni low, asynchronous) empties the block and loads the defaults.
module rsa_symbol_modexp #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic [rsm_pkg::VALUE_W-1:0]          message_value_i,
  input  logic                                 last_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rsm_pkg::VALUE_W-1:0]          result_value_o,
  output logic                                 error_flag_o,
  output logic                                 last_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rsm_pkg::VALUE_W-1:0]          cfg_data_i
);

  logic [MOD_WIDTH-1:0]          modulus;
  logic [rsm_pkg::EXP_W-1:0]     public_exp;
  logic [rsm_pkg::EXP_W-1:0]     private_exp;
  rsm_pkg::dp_cmd_t              cmd;
  rsm_pkg::dp_status_t           status;

  // Configuration registers.
  rsm_cfg_regs #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .modulus_o     (modulus),
    .public_exp_o  (public_exp),
    .private_exp_o (private_exp)
  );

  // Sequencer.
  rsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Multiplier, serial reducer and output register.
  rsm_datapath #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .modulus_i       (modulus),
    .public_exp_i    (public_exp),
    .private_exp_i   (private_exp),
    .func_i          (func_i),
    .message_value_i (message_value_i),
    .last_item_i     (last_item_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .result_value_o  (result_value_o),
    .error_flag_o    (error_flag_o),
    .last_out_o      (last_out_o)
  );

endmodule

@@ hw/rtl/rsm_checker.sv @@
`include "assert_macros.svh"

module rsm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rsm_pkg::VALUE_W-1:0]   result_value_o,
  input logic                          error_flag_o,
  input logic                          last_out_o
);

  // A stalled result beat stays put.
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_value_o) && $stable(error_flag_o) && $stable(last_out_o), "stalled result beat changed")

  // An error beat always carries a zero value.
  `ASSERT_IMPLY(a_err_zero, out_valid_o && error_flag_o, result_value_o == '0, "error beat with non-zero value")

  // Once a beat is taken the block is busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken but block not busy")

  // A new result only appears at the end of work on an item.
  `ASSERT_IMPLY(a_result_after_work, $rose(out_valid_o), $past(in_stall_o), "result appeared while idle")

endmodule

bind rsa_symbol_modexp rsm_checker u_checker (.*);
